@@ rtl/jtok_pkg.sv @@
// Package for the JSON tokenizer: token codes, lexer modes, result types and helper functions.
package jtok_pkg;

    localparam int MAX_STRING = 256;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [30:0] C_INT_MAX = 31'h7FFF_FFFF;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNEXP    = 3'd1;
    localparam logic [2:0] ST_TOO_LONG = 3'd2;
    localparam logic [2:0] ST_END_STR  = 3'd3;
    localparam logic [2:0] ST_INT_SAT  = 3'd4;

    // Character codes
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    // Register index
    localparam logic REG_STRING_LIMIT = 1'b0;

    typedef enum logic [3:0] {
        K_LBRACE  = 4'd0,
        K_RBRACE  = 4'd1,
        K_LSQUARE = 4'd2,
        K_RSQUARE = 4'd3,
        K_COLON   = 4'd4,
        K_COMMA   = 4'd5,
        K_INT     = 4'd6,
        K_SCHAR   = 4'd7,
        K_SEND    = 4'd8,
        K_EOF     = 4'd9,
        K_ERROR   = 4'd10
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_SLASH = 4'd1,
        M_LINE  = 4'd2,
        M_BLOCK = 4'd3,
        M_BSTAR = 4'd4,
        M_INT   = 4'd5,
        M_STR   = 4'd6,
        M_ESC   = 4'd7
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] int_value;
        logic [7:0]  char_value;
        logic [7:0]  length;
        logic [2:0]  status;
        logic        last;
    } t_result;

    // Results produced by one byte, handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    typedef struct packed {
        logic       emit;
        t_kind      kind;
        logic [2:0] status;
        t_mode      mode;
    } t_cls;

    typedef struct packed {
        logic       known;
        logic [7:0] ch;
    } t_esc;

    function automatic t_result mk(input t_kind kind, input logic [30:0] iv,
                                   input logic [7:0] cv, input logic [7:0] len,
                                   input logic [2:0] st);
        t_result r;
        r.kind       = kind;
        r.int_value  = iv;
        r.char_value = cv;
        r.length     = len;
        r.status     = st;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    // Classify a byte seen in idle mode
    function automatic t_cls idle_cls(input logic [7:0] b);
        t_cls c;
        c.emit   = 1'b0;
        c.kind   = K_ERROR;
        c.status = ST_OK;
        c.mode   = M_IDLE;
        case (b)
            CH_SP, CH_LF, CH_CR, CH_TAB, CH_FF: c.emit = 1'b0;
            CH_LBRACE: begin c.emit = 1'b1; c.kind = K_LBRACE;  end
            CH_RBRACE: begin c.emit = 1'b1; c.kind = K_RBRACE;  end
            CH_LSQ:    begin c.emit = 1'b1; c.kind = K_LSQUARE; end
            CH_RSQ:    begin c.emit = 1'b1; c.kind = K_RSQUARE; end
            CH_COLON:  begin c.emit = 1'b1; c.kind = K_COLON;   end
            CH_COMMA:  begin c.emit = 1'b1; c.kind = K_COMMA;   end
            CH_QUOTE:  c.mode = M_STR;
            CH_SLASH:  c.mode = M_SLASH;
            default: begin
                if (is_digit(b)) begin
                    c.mode = M_INT;
                end else begin
                    c.emit   = 1'b1;
                    c.kind   = K_ERROR;
                    c.status = ST_UNEXP;
                end
            end
        endcase
        return c;
    endfunction

    function automatic t_esc translate(input logic [7:0] b);
        t_esc e;
        e.known = 1'b1;
        e.ch    = b;
        case (b)
            CH_A:     e.ch = 8'd7;
            CH_B:     e.ch = 8'd8;
            CH_F:     e.ch = 8'd12;
            CH_N:     e.ch = 8'd10;
            CH_R:     e.ch = 8'd13;
            CH_T:     e.ch = 8'd9;
            CH_V:     e.ch = 8'd11;
            CH_BSL:   e.ch = CH_BSL;
            CH_QUOTE: e.ch = CH_QUOTE;
            CH_APOS:  e.ch = CH_APOS;
            default:  e.known = 1'b0;
        endcase
        return e;
    endfunction

endpackage

@@ rtl/jtok_lexer.sv @@
// Lexer stage: input byte register, lexer state and single-pass result logic.
module jtok_lexer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_byte,
    input  logic                      i_end,
    input  logic [7:0]                i_limit,
    input  logic [jtok_pkg::QAW:0]    i_free,
    output jtok_pkg::t_push           o_push
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_end;

    jtok_pkg::t_mode     r_mode, n_mode;
    logic [30:0]         r_acc, n_acc;
    logic                r_sat, n_sat;
    logic [7:0]          r_cnt, n_cnt;

    logic [7:0]          w_lim0, w_lim;
    logic [7:0]          w_cnt_inc;
    logic                w_hit;
    logic [34:0]         w_sum;
    logic                w_over;
    jtok_pkg::t_cls      w_cls;
    jtok_pkg::t_esc      w_esc;
    jtok_pkg::t_result   w_idle_res;
    jtok_pkg::t_result   w_p, w_t, w_o0, w_o1;
    logic                w_pv, w_tv;
    logic [1:0]          w_n;
    logic                w_fire;

    // Effective string limit
    always_comb begin
        w_lim0 = (i_limit == 8'd0) ? 8'd1 : i_limit;
        w_lim  = w_lim0;
        if (13'(w_lim0) > 13'(jtok_pkg::MAX_STRING - 1)) begin
            w_lim = 8'(jtok_pkg::MAX_STRING - 1);
        end
    end

    assign w_cnt_inc = r_cnt + 8'd1;
    assign w_hit     = (w_cnt_inc >= w_lim);

    // acc * 10 + digit as two shifted adds
    assign w_sum  = 35'({r_acc, 3'b000}) + 35'({r_acc, 1'b0}) + 35'(r_in_byte[3:0]);
    assign w_over = (w_sum > 35'(jtok_pkg::C_INT_MAX));

    assign w_cls = jtok_pkg::idle_cls(r_in_byte);
    assign w_esc = jtok_pkg::translate(r_in_byte);
    assign w_idle_res = jtok_pkg::mk(w_cls.kind, 31'd0,
                                     (w_cls.kind == jtok_pkg::K_ERROR) ? r_in_byte : 8'd0,
                                     8'd0, w_cls.status);

    // Results: an optional leading result, then an optional trailing one
    always_comb begin
        w_pv = 1'b0;
        w_tv = 1'b0;
        w_p  = '0;
        w_t  = '0;
        if (r_in_end) begin
            case (r_mode)
                jtok_pkg::M_SLASH: begin
                    w_pv = 1'b1;
                    w_p  = jtok_pkg::mk(jtok_pkg::K_ERROR, 31'd0, jtok_pkg::CH_SLASH, 8'd0,
                                        jtok_pkg::ST_UNEXP);
                end
                jtok_pkg::M_INT: begin
                    w_pv = 1'b1;
                    w_p  = jtok_pkg::mk(jtok_pkg::K_INT, r_acc, 8'd0, 8'd0,
                                        r_sat ? jtok_pkg::ST_INT_SAT : jtok_pkg::ST_OK);
                end
                jtok_pkg::M_STR, jtok_pkg::M_ESC: begin
                    w_pv = 1'b1;
                    w_p  = jtok_pkg::mk(jtok_pkg::K_SEND, 31'd0, 8'd0, r_cnt,
                                        jtok_pkg::ST_END_STR);
                end
                default: w_pv = 1'b0;
            endcase
            w_tv = 1'b1;
            w_t  = jtok_pkg::mk(jtok_pkg::K_EOF, 31'd0, 8'd0, 8'd0, jtok_pkg::ST_OK);
        end else begin
            case (r_mode)
                jtok_pkg::M_SLASH: begin
                    if (r_in_byte != jtok_pkg::CH_SLASH && r_in_byte != jtok_pkg::CH_STAR) begin
                        w_pv = 1'b1;
                        w_p  = jtok_pkg::mk(jtok_pkg::K_ERROR, 31'd0, jtok_pkg::CH_SLASH,
                                            8'd0, jtok_pkg::ST_UNEXP);
                        w_tv = w_cls.emit;
                        w_t  = w_idle_res;
                    end
                end
                jtok_pkg::M_LINE, jtok_pkg::M_BLOCK, jtok_pkg::M_BSTAR: w_pv = 1'b0;
                jtok_pkg::M_INT: begin
                    if (!jtok_pkg::is_digit(r_in_byte)) begin
                        w_pv = 1'b1;
                        w_p  = jtok_pkg::mk(jtok_pkg::K_INT, r_acc, 8'd0, 8'd0,
                                            r_sat ? jtok_pkg::ST_INT_SAT : jtok_pkg::ST_OK);
                        w_tv = w_cls.emit;
                        w_t  = w_idle_res;
                    end
                end
                jtok_pkg::M_STR: begin
                    if (r_in_byte == jtok_pkg::CH_QUOTE) begin
                        w_pv = 1'b1;
                        w_p  = jtok_pkg::mk(jtok_pkg::K_SEND, 31'd0, 8'd0, r_cnt,
                                            jtok_pkg::ST_OK);
                    end else if (r_in_byte != jtok_pkg::CH_BSL) begin
                        w_pv = 1'b1;
                        w_p  = jtok_pkg::mk(jtok_pkg::K_SCHAR, 31'd0, r_in_byte, 8'd0,
                                            jtok_pkg::ST_OK);
                        w_tv = w_hit;
                        w_t  = jtok_pkg::mk(jtok_pkg::K_SEND, 31'd0, 8'd0, w_cnt_inc,
                                            jtok_pkg::ST_TOO_LONG);
                    end
                end
                jtok_pkg::M_ESC: begin
                    w_pv = 1'b1;
                    w_p  = jtok_pkg::mk(jtok_pkg::K_SCHAR, 31'd0, w_esc.ch, 8'd0,
                                        w_esc.known ? jtok_pkg::ST_OK : jtok_pkg::ST_UNEXP);
                    w_tv = w_hit;
                    w_t  = jtok_pkg::mk(jtok_pkg::K_SEND, 31'd0, 8'd0, w_cnt_inc,
                                        jtok_pkg::ST_TOO_LONG);
                end
                default: begin
                    w_tv = w_cls.emit;
                    w_t  = w_idle_res;
                end
            endcase
        end
    end

    // Pack results to the front and mark the last one
    always_comb begin
        w_o1 = '0;
        if (w_pv) begin
            w_o0 = w_p;
            w_o1 = w_t;
            w_n  = w_tv ? 2'd2 : 2'd1;
        end else begin
            w_o0 = w_t;
            w_n  = w_tv ? 2'd1 : 2'd0;
        end
        if (w_n == 2'd2) begin
            w_o1.last = 1'b1;
        end else begin
            w_o0.last = 1'b1;
        end
    end

    // Next lexer state
    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        if (r_in_end) begin
            n_mode = jtok_pkg::M_IDLE;
            n_acc  = 31'd0;
            n_sat  = 1'b0;
            n_cnt  = 8'd0;
        end else begin
            case (r_mode)
                jtok_pkg::M_SLASH: begin
                    if (r_in_byte == jtok_pkg::CH_SLASH) begin
                        n_mode = jtok_pkg::M_LINE;
                    end else if (r_in_byte == jtok_pkg::CH_STAR) begin
                        n_mode = jtok_pkg::M_BLOCK;
                    end else begin
                        n_mode = w_cls.mode;
                    end
                end
                jtok_pkg::M_LINE: begin
                    if (r_in_byte == jtok_pkg::CH_LF) n_mode = jtok_pkg::M_IDLE;
                end
                jtok_pkg::M_BLOCK: begin
                    if (r_in_byte == jtok_pkg::CH_STAR) n_mode = jtok_pkg::M_BSTAR;
                end
                jtok_pkg::M_BSTAR: begin
                    if (r_in_byte == jtok_pkg::CH_SLASH) begin
                        n_mode = jtok_pkg::M_IDLE;
                    end else if (r_in_byte != jtok_pkg::CH_STAR) begin
                        n_mode = jtok_pkg::M_BLOCK;
                    end
                end
                jtok_pkg::M_INT: begin
                    if (jtok_pkg::is_digit(r_in_byte)) begin
                        n_acc = w_over ? jtok_pkg::C_INT_MAX : w_sum[30:0];
                        n_sat = r_sat | w_over;
                    end else begin
                        n_mode = w_cls.mode;
                        n_acc  = 31'd0;
                        n_sat  = 1'b0;
                    end
                end
                jtok_pkg::M_STR: begin
                    if (r_in_byte == jtok_pkg::CH_QUOTE) begin
                        n_mode = jtok_pkg::M_IDLE;
                        n_cnt  = 8'd0;
                    end else if (r_in_byte == jtok_pkg::CH_BSL) begin
                        n_mode = jtok_pkg::M_ESC;
                    end else begin
                        n_mode = w_hit ? jtok_pkg::M_IDLE : jtok_pkg::M_STR;
                        n_cnt  = w_hit ? 8'd0 : w_cnt_inc;
                    end
                end
                jtok_pkg::M_ESC: begin
                    n_mode = w_hit ? jtok_pkg::M_IDLE : jtok_pkg::M_STR;
                    n_cnt  = w_hit ? 8'd0 : w_cnt_inc;
                end
                default: begin
                    n_mode = w_cls.mode;
                end
            endcase
            // Entering a token from idle-style dispatch
            if (r_mode != jtok_pkg::M_INT && r_mode != jtok_pkg::M_STR &&
                r_mode != jtok_pkg::M_ESC && r_mode != jtok_pkg::M_LINE &&
                r_mode != jtok_pkg::M_BLOCK && r_mode != jtok_pkg::M_BSTAR) begin
                if (w_cls.mode == jtok_pkg::M_INT && n_mode == jtok_pkg::M_INT) begin
                    n_acc = 31'(r_in_byte[3:0]);
                    n_sat = 1'b0;
                end
                if (w_cls.mode == jtok_pkg::M_STR && n_mode == jtok_pkg::M_STR) begin
                    n_cnt = 8'd0;
                end
            end
        end
    end

    assign w_fire  = r_in_valid && ((jtok_pkg::QAW + 1)'(w_n) <= i_free);
    assign o_ready = !r_in_valid || w_fire;

    always_comb begin
        o_push.count = w_fire ? w_n : 2'd0;
        o_push.r0    = w_o0;
        o_push.r1    = w_o1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_end  <= i_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jtok_pkg::M_IDLE;
            r_acc  <= 31'd0;
            r_sat  <= 1'b0;
            r_cnt  <= 8'd0;
        end else if (w_fire) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_sat  <= n_sat;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ rtl/jtok_outq.sv @@
// Result queue: takes up to two results per cycle, delivers one per transfer.
module jtok_outq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  jtok_pkg::t_push           i_push,
    output logic [jtok_pkg::QAW:0]    o_free,
    output logic                      o_valid,
    input  logic                      i_ready,
    output jtok_pkg::t_result         o_result
);

    jtok_pkg::t_result                r_mem [jtok_pkg::QDEPTH];
    logic [jtok_pkg::QAW-1:0]         r_wr, r_rd;
    logic [jtok_pkg::QAW:0]           r_count;
    logic [jtok_pkg::QAW-1:0]         w_wr1;
    logic                             w_pop;

    assign o_valid  = (r_count != '0);
    assign w_pop    = o_valid && i_ready;
    assign o_free   = (jtok_pkg::QAW + 1)'(jtok_pkg::QDEPTH) - r_count
                    + (jtok_pkg::QAW + 1)'(w_pop);
    assign w_wr1    = r_wr + jtok_pkg::QAW'(1);
    assign o_result = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[w_wr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + jtok_pkg::QAW'(i_push.count);
            r_rd    <= r_rd + jtok_pkg::QAW'(w_pop);
            r_count <= r_count + (jtok_pkg::QAW + 1)'(i_push.count)
                     - (jtok_pkg::QAW + 1)'(w_pop);
        end
    end

endmodule

@@ rtl/json_tokenizer.sv @@
// Path: an accepted byte is held in the lexer input register; its results are written to
// the result queue, which drives m_axis. Throughput: one byte per cycle while the queue
// has room for its results; a second result from one byte is absorbed by the four-entry
// queue. The lexer state update (byte in, mode/accumulator/count out) is the feedback loop.
// Reset: synchronous, active low; returns the lexer to idle, empties the queue and sets
// string_limit to 255. No clearing pass.
module json_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [30:0] int_value, [38:31] char_value,
                                        // [46:39] string_length, [49:47] status, rest zero
    output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
    output logic        m_axis_tlast,   // last_of_step
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]                 r_string_limit;
    jtok_pkg::t_push            w_push;
    logic [jtok_pkg::QAW:0]     w_free;
    jtok_pkg::t_result          w_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == jtok_pkg::REG_STRING_LIMIT) ? {24'd0, r_string_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_limit <= 8'd255;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == jtok_pkg::REG_STRING_LIMIT) begin
            r_string_limit <= pwdata[7:0];
        end
    end

    jtok_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_end   (s_axis_tlast),
        .i_limit (r_string_limit),
        .i_free  (w_free),
        .o_push  (w_push)
    );

    jtok_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_free   (w_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_res)
    );

    assign m_axis_tdata = {6'd0, w_res.status, w_res.length, w_res.char_value, w_res.int_value};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

endmodule

@@ rtl/jtok_checker.sv @@
// Port-level checks for the JSON tokenizer and their bind to the top level.
module jtok_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        pready
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // eof always closes the results of its byte
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == 4'(jtok_pkg::K_EOF) |-> m_axis_tlast)
        else $error("eof without tlast");

    // Only an int, error, string char or string end can lead a pair of results
    a_first_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            (m_axis_tuser == 4'(jtok_pkg::K_INT) || m_axis_tuser == 4'(jtok_pkg::K_ERROR) ||
             m_axis_tuser == 4'(jtok_pkg::K_SCHAR) || m_axis_tuser == 4'(jtok_pkg::K_SEND)))
        else $error("unexpected leading token kind");

    // The second result of a byte is ready right after the first transfers
    a_pair_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of a byte missing");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind json_tokenizer jtok_checker u_jtok_checker (.*);
